/* design/sukt_pkg.sv */
package sukt_pkg;

  // Default table size
  localparam int DEF_CAPACITY = 32;

  // Field widths
  localparam int MODE_W   = 3;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int RANK_W   = 6;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP_ASC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP_DESC = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_DUMP      = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] key_out;
    logic [RANK_W-1:0]       rank;
    logic                    last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_EXEC,
    S_DUMP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic dump_start;
    logic dump_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_mode_ok;
    logic is_dump;
    logic empty;
    logic out_free;
    logic dump_last;
  } stat_t;

endpackage

/* design/sukt_ctrl.sv */
module sukt_ctrl import sukt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        // drop beats with an unused mode
        if (in_valid && stat.in_mode_ok) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_dump && !stat.empty) begin
          cmd.dump_start = 1'b1;
          state_next     = S_DUMP;
        end else if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.dump_load = 1'b1;
          if (stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/sukt_dpath.sv */
module sukt_dpath import sukt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [KEY_W-1:0] cells [CAPACITY];
  logic signed [KEY_W-1:0] ins_val [CAPACITY];
  logic signed [KEY_W-1:0] del_val [CAPACITY];
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic [MODE_W-1:0]       mode;
  logic signed [KEY_W-1:0] key;
  logic [CAPACITY-1:0]     lt;
  logic [CAPACITY-1:0]     eq;
  logic [CAPACITY:0]       bound;
  logic [CW-1:0]           pos;
  logic [CW:0]             pos_inc;
  logic [CW-1:0]           addr_full;
  logic [CW:0]             addr_inc;
  logic [AW-1:0]           addr;
  logic                    dup;
  logic                    full;
  logic                    empty;
  logic                    do_ins;
  logic                    do_del;
  logic                    dump_last;
  out_item_t               op_res;
  out_item_t               dump_res;

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode <= in_data.mode;
      key  <= in_data.key;
    end
  end

  // Compare every live cell against the key
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] <= (CW'(i) < count) && (cells[i] < key);
      eq[i] <= (CW'(i) < count) && (cells[i] == key);
    end
  end

  // Find the edge of the less-than run: one-hot position marker
  always_comb begin
    bound[0] = ~lt[0];
    for (int i = 1; i < CAPACITY; i++) begin
      bound[i] = lt[i-1] & ~lt[i];
    end
    bound[CAPACITY] = lt[CAPACITY-1];
  end

  // Encode the marker into a position
  always_comb begin
    pos = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      pos = pos | (bound[i] ? CW'(i) : '0);
    end
  end

  assign pos_inc = {1'b0, pos} + (CW + 1)'(1);
  assign dup     = |eq;
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign do_ins  = cmd.exec && (mode == MODE_INSERT) && !dup && !full;
  assign do_del  = cmd.exec && (mode == MODE_DELETE) && dup;

  // Shift values for insert (open a gap) and delete (close it)
  always_comb begin
    ins_val[0] = key;
    for (int i = 1; i < CAPACITY; i++) begin
      ins_val[i] = bound[i] ? key : cells[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      del_val[i] = cells[i+1];
    end
    del_val[CAPACITY-1] = cells[CAPACITY-1];
  end

  // Cell row: cells below the position hold, the rest move
  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!lt[i]) begin
          cells[i] <= ins_val[i];
        end
      end
    end else if (do_del) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!lt[i]) begin
          cells[i] <= del_val[i];
        end
      end
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + CW'(1);
    end else if (do_del) begin
      count <= count - CW'(1);
    end
  end

  // Single result of insert, delete or search, or of a dump on an empty table
  always_comb begin
    op_res.key_out = key;
    op_res.rank    = '0;
    op_res.last    = 1'b1;
    op_res.status  = ST_EMPTY;
    if (mode != MODE_INSERT && empty) begin
      op_res.status = ST_EMPTY;
    end else begin
      case (mode)
        MODE_INSERT: begin
          if (dup) begin
            op_res.status = ST_DUPLICATE;
            op_res.rank   = RANK_W'(pos_inc);
          end else if (full) begin
            op_res.status = ST_FULL;
          end else begin
            op_res.status = ST_INSERTED;
            op_res.rank   = RANK_W'(pos_inc);
          end
        end
        MODE_DELETE, MODE_SEARCH: begin
          if (!dup) begin
            op_res.status = ST_NOTFOUND;
          end else begin
            op_res.status = (mode == MODE_DELETE) ? ST_DELETED : ST_FOUND;
            op_res.rank   = RANK_W'(pos_inc);
          end
        end
        default: begin
          op_res.status = ST_EMPTY;
        end
      endcase
    end
  end

  // Dump index
  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      idx <= '0;
    end else if (cmd.dump_load) begin
      idx <= idx + CW'(1);
    end
  end

  // Dump record at the current index
  assign addr_full = (mode == MODE_DUMP_DESC) ? (count - CW'(1) - idx) : idx;
  assign addr      = addr_full[AW-1:0];
  assign addr_inc  = {1'b0, addr_full} + (CW + 1)'(1);
  assign dump_last = (idx == count - CW'(1));

  always_comb begin
    dump_res.status  = ST_DUMP;
    dump_res.key_out = cells[addr];
    dump_res.rank    = RANK_W'(addr_inc);
    dump_res.last    = dump_last;
  end

  // Output register: load a beat, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.dump_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= op_res;
    end else if (cmd.dump_load) begin
      out_data <= dump_res;
    end
  end

  // Status to the controller
  assign stat.in_mode_ok = in_data.mode inside {[MODE_INSERT:MODE_DUMP_DESC]};
  assign stat.is_dump    = mode inside {MODE_DUMP_ASC, MODE_DUMP_DESC};
  assign stat.empty      = empty;
  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.dump_last  = dump_last;

endmodule

/* design/sorted_unique_key_table_top.sv */
// Sorted unique key table: holds up to CAPACITY distinct signed keys in
// ascending order in a row of cells.
// Input channel (in_valid/in_stall/in_data) carries one beat per operation:
// insert, delete, search, dump ascending or dump descending. Beats with an
// unused mode are taken and dropped without a result.
// Output channel (out_valid/out_stall/out_data) carries result beats: one for
// insert, delete, search and for any operation on an empty table, one per
// stored key for a dump, with last set on the final beat.
// Timing: the accepting edge captures the beat, the compare state registers
// a compare of every cell against the key in parallel, and the execute state
// shifts the cell row and loads the result into the output register, waiting
// while the receiver stalls a result still held there. The next beat is taken
// back in idle, so no new beat is taken before the last one is done. A dump
// loads one record per cycle while the output is not stalled, and the next
// beat is taken after its last record.
// Reset empties the table and clears the output register.
// When the receiver stalls, the result beat holds in the output register and
// the controller waits; in_stall stays high until the operation is done.
module sorted_unique_key_table_top import sukt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  sukt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sukt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
